/* design/assert_macros.svh */
// assertion helpers used by the tracker engine
// both expect a clock named aclk in the module that uses them, the first also aresetn
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SRRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define SRRT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* design/srrt_pkg.sv */
package srrt_pkg;

    // fixed field widths
    localparam int SEQ_W       = 11;
    localparam int TS_W        = 32;
    localparam int SLOT_W      = 5;
    localparam int WIN_W       = 16;
    localparam int CNT_W       = 5;
    // wide enough for any lost count or slot count before truncation
    localparam int CNT_CALC_W  = 7;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_TUSER_W = 4;

    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_FIN   = 2'd1,
        CMD_OTHER = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ACK          = 3'd0,
        KIND_LOST         = 3'd1,
        KIND_ALL_RECEIVED = 3'd2,
        KIND_IGNORED      = 3'd3,
        KIND_BAD_SEQ      = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DATA,
        ST_RESP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_END
    } state_t;

    // one result word handed from the sequencer to the output register
    typedef struct packed {
        logic               load;
        kind_t              kind;
        logic [SEQ_W-1:0]   ack_seq;
        logic [TS_W-1:0]    echo_time;
        logic [CNT_W-1:0]   ack_count;
        logic [WIN_W-1:0]   window;
        logic               payload_new;
        logic               last;
    } resp_t;

endpackage

/* design/srrt_ram.sv */
module srrt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/srrt_engine.sv */
`include "assert_macros.svh"

module srrt_engine #(
    parameter int MAX_PACKETS = 1024,
    parameter int MAX_LOST    = 20,
    localparam int AW         = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_accept,
    input  srrt_pkg::cmd_t                in_cmd,
    input  logic [srrt_pkg::SEQ_W-1:0]    in_seq,
    input  logic [srrt_pkg::SEQ_W-1:0]    in_total,
    input  logic [srrt_pkg::TS_W-1:0]     in_timestamp,
    input  logic [srrt_pkg::SLOT_W-1:0]   in_slot,
    input  logic [srrt_pkg::WIN_W-1:0]    in_window,
    input  logic                          out_free,
    output logic                          ready,
    output logic                          ram_rd_en,
    output logic [AW-1:0]                 ram_rd_addr,
    input  logic                          ram_rd_data,
    output logic                          ram_wr_en,
    output logic [AW-1:0]                 ram_wr_addr,
    output logic                          ram_wr_data,
    output srrt_pkg::resp_t               resp
);

    localparam int CW     = $clog2(MAX_PACKETS + 1);
    localparam int WW     = (CW > srrt_pkg::SEQ_W) ? CW : srrt_pkg::SEQ_W;
    localparam int LW     = $clog2(MAX_LOST + 1);
    localparam int CALC_W = srrt_pkg::CNT_CALC_W;

    srrt_pkg::state_t                state_reg, state_next;
    logic [srrt_pkg::SEQ_W-1:0]      seq_reg, seq_next;
    logic [srrt_pkg::SEQ_W-1:0]      total_in_reg, total_in_next;
    logic [srrt_pkg::TS_W-1:0]       ts_reg, ts_next;
    logic [srrt_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [srrt_pkg::WIN_W-1:0]      win_reg, win_next;
    logic [srrt_pkg::SEQ_W-1:0]      exp_total_reg, exp_total_next;
    logic [WW-1:0]                   idx_reg, idx_next;
    logic [LW-1:0]                   n_reg, n_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [srrt_pkg::SEQ_W-1:0]      pend_idx_reg, pend_idx_next;

    logic [WW-1:0]                   seq_m1_in;
    logic [WW-1:0]                   seq_m1;
    logic                            seq_ok;
    logic [WW-1:0]                   limit;
    logic                            scan_go;
    logic                            clear_done;
    logic [CALC_W-1:0]               slot_ext;
    logic [CALC_W-1:0]               slot_clamped;
    logic [CALC_W-1:0]               slot_cnt;
    logic [CALC_W-1:0]               n_ext;
    logic                            miss;
    logic                            push_blocked;

    // sequence checks and bitmap addresses
    assign seq_m1_in = WW'(in_seq) - WW'(1);
    assign seq_m1    = WW'(seq_reg) - WW'(1);
    assign seq_ok    = (seq_reg != '0) && (WW'(seq_reg) <= WW'(MAX_PACKETS));

    // index compares: scan bound and clear sweep end
    assign limit      = (WW'(exp_total_reg) < WW'(MAX_PACKETS)) ? WW'(exp_total_reg)
                                                                 : WW'(MAX_PACKETS);
    assign scan_go    = (idx_reg < limit) && (n_reg < LW'(MAX_LOST));
    assign clear_done = (idx_reg == WW'(MAX_PACKETS - 1));

    // slot count saturates at the lost list length
    assign slot_ext     = CALC_W'(slot_reg);
    assign slot_clamped = (slot_ext > CALC_W'(MAX_LOST - 1)) ? CALC_W'(MAX_LOST - 1)
                                                             : slot_ext;
    assign slot_cnt     = slot_clamped + CALC_W'(1);
    assign n_ext        = CALC_W'(n_reg);

    // a missing entry found while the previous one still waits for the output
    assign miss         = !ram_rd_data;
    assign push_blocked = miss && pend_valid_reg && !out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srrt_pkg::ST_CLEAR: begin
                if (clear_done) begin
                    state_next = srrt_pkg::ST_IDLE;
                end
            end
            srrt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    unique case (in_cmd)
                        srrt_pkg::CMD_DATA:  state_next = srrt_pkg::ST_DATA;
                        srrt_pkg::CMD_FIN:   state_next = srrt_pkg::ST_SCAN_RD;
                        srrt_pkg::CMD_OTHER: state_next = srrt_pkg::ST_RESP;
                        srrt_pkg::CMD_CLEAR: state_next = srrt_pkg::ST_CLEAR;
                    endcase
                end
            end
            srrt_pkg::ST_DATA, srrt_pkg::ST_RESP, srrt_pkg::ST_SCAN_END: begin
                if (out_free) begin
                    state_next = srrt_pkg::ST_IDLE;
                end
            end
            srrt_pkg::ST_SCAN_RD: begin
                state_next = scan_go ? srrt_pkg::ST_SCAN_CHK : srrt_pkg::ST_SCAN_END;
            end
            srrt_pkg::ST_SCAN_CHK: begin
                if (!push_blocked) begin
                    state_next = srrt_pkg::ST_SCAN_RD;
                end
            end
            default: state_next = srrt_pkg::ST_CLEAR;
        endcase
    end

    // datapath register updates
    always_comb begin
        seq_next        = seq_reg;
        total_in_next   = total_in_reg;
        ts_next         = ts_reg;
        slot_next       = slot_reg;
        win_next        = win_reg;
        exp_total_next  = exp_total_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        unique case (state_reg)
            srrt_pkg::ST_CLEAR: begin
                idx_next = idx_reg + WW'(1);
            end
            srrt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    seq_next        = in_seq;
                    total_in_next   = in_total;
                    ts_next         = in_timestamp;
                    slot_next       = in_slot;
                    win_next        = in_window;
                    idx_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    if (in_cmd == srrt_pkg::CMD_CLEAR) begin
                        exp_total_next = '0;
                    end
                end
            end
            srrt_pkg::ST_DATA: begin
                if (out_free && seq_ok) begin
                    exp_total_next = total_in_reg;
                end
            end
            srrt_pkg::ST_SCAN_CHK: begin
                if (!miss) begin
                    idx_next = idx_reg + WW'(1);
                end else if (!push_blocked) begin
                    pend_idx_next   = idx_reg[srrt_pkg::SEQ_W-1:0];
                    pend_valid_next = 1'b1;
                    n_next          = n_reg + LW'(1);
                    idx_next        = idx_reg + WW'(1);
                end
            end
            srrt_pkg::ST_SCAN_END: begin
                if (out_free) begin
                    pend_valid_next = 1'b0;
                end
            end
            srrt_pkg::ST_RESP, srrt_pkg::ST_SCAN_RD: begin
            end
            default: begin
            end
        endcase
    end

    // outputs: handshake, bitmap port and result word
    always_comb begin
        ready       = (state_reg == srrt_pkg::ST_IDLE);
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg[AW-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg[AW-1:0];
        ram_wr_data = 1'b0;
        resp        = '0;
        unique case (state_reg)
            srrt_pkg::ST_CLEAR: begin
                ram_wr_en = 1'b1;
            end
            srrt_pkg::ST_IDLE: begin
                if (in_accept && in_cmd == srrt_pkg::CMD_DATA) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = seq_m1_in[AW-1:0];
                end
            end
            srrt_pkg::ST_DATA: begin
                if (out_free) begin
                    ram_wr_en        = seq_ok;
                    ram_wr_addr      = seq_m1[AW-1:0];
                    ram_wr_data      = 1'b1;
                    resp.load        = 1'b1;
                    resp.kind        = seq_ok ? srrt_pkg::KIND_ACK : srrt_pkg::KIND_BAD_SEQ;
                    resp.ack_seq     = seq_reg;
                    resp.echo_time   = ts_reg;
                    resp.ack_count   = slot_cnt[srrt_pkg::CNT_W-1:0];
                    resp.window      = win_reg;
                    resp.payload_new = seq_ok && !ram_rd_data;
                    resp.last        = 1'b1;
                end
            end
            srrt_pkg::ST_RESP: begin
                if (out_free) begin
                    resp.load = 1'b1;
                    resp.kind = srrt_pkg::KIND_IGNORED;
                    resp.last = 1'b1;
                end
            end
            srrt_pkg::ST_SCAN_RD: begin
                ram_rd_en = scan_go;
            end
            srrt_pkg::ST_SCAN_CHK: begin
                // the held-back index goes out once a later one is known
                if (miss && pend_valid_reg && out_free) begin
                    resp.load      = 1'b1;
                    resp.kind      = srrt_pkg::KIND_LOST;
                    resp.ack_seq   = pend_idx_reg;
                    resp.ack_count = n_ext[srrt_pkg::CNT_W-1:0];
                end
            end
            srrt_pkg::ST_SCAN_END: begin
                if (out_free) begin
                    resp.load = 1'b1;
                    resp.last = 1'b1;
                    if (pend_valid_reg) begin
                        resp.kind      = srrt_pkg::KIND_LOST;
                        resp.ack_seq   = pend_idx_reg;
                        resp.ack_count = n_ext[srrt_pkg::CNT_W-1:0];
                    end else begin
                        resp.kind = srrt_pkg::KIND_ALL_RECEIVED;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= srrt_pkg::ST_CLEAR;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            exp_total_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            exp_total_reg  <= exp_total_next;
        end
    end

    // captured word and pending lost index
    always_ff @(posedge aclk) begin
        seq_reg      <= seq_next;
        total_in_reg <= total_in_next;
        ts_reg       <= ts_next;
        slot_reg     <= slot_next;
        win_reg      <= win_next;
        pend_idx_reg <= pend_idx_next;
    end

    `SRRT_ASSERT(a_lost_bound, n_reg <= LW'(MAX_LOST), "lost count past list length")
    `SRRT_ASSERT(a_load_free, resp.load |-> out_free, "result loaded into a full output")
    `SRRT_ASSERT(a_clear_start,
                 (in_accept && in_cmd == srrt_pkg::CMD_CLEAR) |=>
                 (state_reg == srrt_pkg::ST_CLEAR && idx_reg == '0),
                 "clear sweep not started")
    `SRRT_ASSERT(a_pend_count, pend_valid_reg |-> (n_reg != '0), "pending index without count")
    `SRRT_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> (state_reg == srrt_pkg::ST_CLEAR),
                        "reset did not start clear sweep")

endmodule

/* design/selective_repeat_receive_tracker.sv */
// channel  | dir | ports                        | word
// s_       | in  | tvalid tready tdata tuser    | one packet event or clear command
// m_       | out | tvalid tready tdata tuser tlast | one ack, lost report or status
//
// a data or bad-sequence word reads its bitmap entry on accept; a data word then writes
// the entry back set as its result goes out, an ignored word leaves the bitmap alone.
// a fin word scans the bitmap with a read state then a check state per entry,
// min(total, MAX_PACKETS) entries at most, stopping once MAX_LOST are found lost.
// clear and reset run a sweep over all MAX_PACKETS entries of the bitmap ram,
// s_tready stays low meanwhile.
// a full output register stalls the sequencer only when a result is due.
module selective_repeat_receive_tracker #(
    parameter int MAX_PACKETS = 1024,
    parameter int MAX_LOST    = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // seq[10:0] total[21:11] timestamp[53:22] ack_slot[58:54] window[74:59], zero pad
    input  logic [srrt_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // ack_seq[10:0] echo_time[42:11] ack_count[47:43] advertised_window[63:48]
    output logic [srrt_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // kind[2:0] payload_new[3]
    output logic [srrt_pkg::OUT_TUSER_W-1:0]    m_tuser,
    output logic                                m_tlast
);

    localparam int AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;

    logic               in_accept;
    logic               engine_ready;
    logic               out_free;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic               ram_rd_data;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic               ram_wr_data;
    srrt_pkg::resp_t    resp;
    srrt_pkg::resp_t    out_reg;

    // input handshake
    assign s_tready  = engine_ready;
    assign in_accept = s_tvalid && engine_ready;

    // output register frees when empty or being taken
    assign out_free = !out_reg.load || m_tready;

    srrt_engine #(
        .MAX_PACKETS (MAX_PACKETS),
        .MAX_LOST    (MAX_LOST)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .in_cmd       (srrt_pkg::cmd_t'(s_tuser)),
        .in_seq       (s_tdata[10:0]),
        .in_total     (s_tdata[21:11]),
        .in_timestamp (s_tdata[53:22]),
        .in_slot      (s_tdata[58:54]),
        .in_window    (s_tdata[74:59]),
        .out_free     (out_free),
        .ready        (engine_ready),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .resp         (resp)
    );

    // received bitmap
    srrt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PACKETS)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register, load bit doubles as valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.load <= 1'b0;
        end else if (resp.load) begin
            out_reg <= resp;
        end else if (m_tready) begin
            out_reg.load <= 1'b0;
        end
    end

    assign m_tvalid = out_reg.load;
    assign m_tdata  = {out_reg.window, out_reg.ack_count, out_reg.echo_time, out_reg.ack_seq};
    assign m_tuser  = {out_reg.payload_new, out_reg.kind};
    assign m_tlast  = out_reg.last;

endmodule

/* tb/selective_repeat_receive_tracker_tb.sv */
module selective_repeat_receive_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PACKET_CAP = 1024;
    localparam int LOST_CAP   = 20;
    // longest quiet stretch of a correct run is a full bitmap scan
    localparam int QUIET_LIMIT = 12000;
    // a fin over the whole bitmap is the slowest thing the block does
    localparam int TAIL_CYCLES = 2 * PACKET_CAP + 16;
    localparam int RANDOM_WORDS = 320;

    // one result word as the block should present it
    typedef struct packed {
        srrt_pkg::kind_t                kind;
        logic [srrt_pkg::SEQ_W-1:0]     seq;
        logic [srrt_pkg::TS_W-1:0]      echo;
        logic [srrt_pkg::CNT_W-1:0]     count;
        logic [srrt_pkg::WIN_W-1:0]     win;
        logic                           fresh;
        logic                           last;
    } ack_word_t;

    logic                                   aclk;
    logic                                   aresetn  = 1'b0;
    logic                                   s_tvalid = 1'b0;
    logic                                   s_tready;
    logic [srrt_pkg::IN_TDATA_W-1:0]        s_tdata  = '0;
    logic [1:0]                             s_tuser  = '0;
    logic                                   m_tvalid;
    logic                                   m_tready = 1'b0;
    logic [srrt_pkg::OUT_TDATA_W-1:0]       m_tdata;
    logic [srrt_pkg::OUT_TUSER_W-1:0]       m_tuser;
    logic                                   m_tlast;

    // predictor state: which packets have arrived and the message total
    logic [PACKET_CAP-1:0]                  packet_seen   = '0;
    logic [srrt_pkg::SEQ_W-1:0]             message_total = '0;
    ack_word_t                              ack_words_due[$];

    int  words_sent    = 0;
    int  words_checked = 0;
    int  fail_count    = 0;
    int  quiet_cycles  = 0;
    int  kind_tally[5] = '{default: 0};
    bit  steady_run    = 1'b0;

    selective_repeat_receive_tracker #(
        .MAX_PACKETS(PACKET_CAP),
        .MAX_LOST   (LOST_CAP)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // work out the result words one accepted packet word causes
    task automatic track_packet(input srrt_pkg::cmd_t cmd,
                                input logic [srrt_pkg::SEQ_W-1:0] seq,
                                input logic [srrt_pkg::SEQ_W-1:0] total,
                                input logic [srrt_pkg::TS_W-1:0] ts,
                                input logic [srrt_pkg::SLOT_W-1:0] slot,
                                input logic [srrt_pkg::WIN_W-1:0] win);
        ack_word_t   w;
        int unsigned lost_idx[$];
        int unsigned scan_end;
        int unsigned i;
        logic [srrt_pkg::SLOT_W-1:0] slot_sat;
        slot_sat = (slot > LOST_CAP - 1) ? srrt_pkg::SLOT_W'(LOST_CAP - 1) : slot;
        w = '0;
        w.last = 1'b1;
        case (cmd)
            srrt_pkg::CMD_DATA: begin
                w.seq   = seq;
                w.echo  = ts;
                w.count = srrt_pkg::CNT_W'(slot_sat + 1);
                w.win   = win;
                if (seq == 0 || seq > PACKET_CAP) begin
                    w.kind = srrt_pkg::KIND_BAD_SEQ;
                end else begin
                    w.kind  = srrt_pkg::KIND_ACK;
                    w.fresh = !packet_seen[seq - 1];
                    packet_seen[seq - 1] = 1'b1;
                    message_total = total;
                end
                ack_words_due.push_back(w);
            end
            srrt_pkg::CMD_FIN: begin
                // scan is capped at the bitmap size and at the lost list length
                scan_end = (message_total > PACKET_CAP) ? PACKET_CAP : message_total;
                for (i = 0; i < scan_end && lost_idx.size() < LOST_CAP; i++) begin
                    if (!packet_seen[i]) lost_idx.push_back(i);
                end
                if (lost_idx.size() == 0) begin
                    w.kind = srrt_pkg::KIND_ALL_RECEIVED;
                    ack_words_due.push_back(w);
                end else begin
                    for (i = 0; i < lost_idx.size(); i++) begin
                        w       = '0;
                        w.kind  = srrt_pkg::KIND_LOST;
                        w.seq   = srrt_pkg::SEQ_W'(lost_idx[i]);
                        w.count = srrt_pkg::CNT_W'(i + 1);
                        w.last  = (i == lost_idx.size() - 1);
                        ack_words_due.push_back(w);
                    end
                end
            end
            srrt_pkg::CMD_OTHER: begin
                w.kind = srrt_pkg::KIND_IGNORED;
                ack_words_due.push_back(w);
            end
            default: begin
                // clear starts a new message and gives no word
                packet_seen   = '0;
                message_total = '0;
            end
        endcase
    endtask

    // offer one packet word, with random gaps outside the steady stretch, and wait for it to be taken
    task automatic send_packet(input srrt_pkg::cmd_t cmd,
                               input logic [srrt_pkg::SEQ_W-1:0] seq,
                               input logic [srrt_pkg::SEQ_W-1:0] total,
                               input logic [srrt_pkg::TS_W-1:0] ts,
                               input logic [srrt_pkg::SLOT_W-1:0] slot,
                               input logic [srrt_pkg::WIN_W-1:0] win);
        while (!steady_run && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, win, slot, ts, total, seq};
        do @(posedge aclk); while (!s_tready);
        track_packet(cmd, seq, total, ts, slot, win);
        words_sent++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // result side stalls at random except during the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady_run || ($urandom_range(0, 99) >= 25);
    end

    // compare every result word with the oldest prediction
    always @(posedge aclk) begin
        ack_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (ack_words_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, %s tdata=%h tuser=%h tlast=%b",
                         $time, "actual", m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                want = ack_words_due.pop_front();
                check_field("kind",              want.kind,  m_tuser[2:0]);
                check_field("ack_seq",           want.seq,   m_tdata[10:0]);
                check_field("echo_time",         want.echo,  m_tdata[42:11]);
                check_field("ack_count",         want.count, m_tdata[47:43]);
                check_field("advertised_window", want.win,   m_tdata[63:48]);
                check_field("payload_new",       want.fresh, m_tuser[3]);
                check_field("last",              want.last,  m_tlast);
                kind_tally[want.kind]++;
                words_checked++;
            end
        end
    end

    // give up if no word moves on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d result words still due", $time, ack_words_due.size());
            $display("selective_repeat_receive_tracker_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // fresh block: fin over an empty message and an unknown packet type
    task automatic test_empty_message();
        send_packet(srrt_pkg::CMD_FIN,   11'd0,   11'd0,   32'h0,        5'd0,  16'h0);
        send_packet(srrt_pkg::CMD_OTHER, 11'h7ff, 11'h7ff, 32'hffffffff, 5'd31, 16'hffff);
    endtask

    // acks, duplicates and slot saturation
    task automatic test_data_acks();
        send_packet(srrt_pkg::CMD_DATA, 11'd1,    11'd3,    32'h0,        5'd0,  16'h0);
        send_packet(srrt_pkg::CMD_DATA, 11'd1024, 11'd1024, 32'hffffffff, 5'd19, 16'hffff);
        send_packet(srrt_pkg::CMD_DATA, 11'd1,    11'd3,    32'ha5a55a5a, 5'd31, 16'h1234);
        send_packet(srrt_pkg::CMD_DATA, 11'd3,    11'd3,    32'h5a5aa5a5, 5'd20, 16'hedcb);
    endtask

    // sequence zero and beyond the bitmap must leave state alone
    task automatic test_bad_sequence();
        send_packet(srrt_pkg::CMD_DATA, 11'd0,    11'h7ff, 32'h12345678, 5'd31, 16'h8000);
        send_packet(srrt_pkg::CMD_DATA, 11'd1025, 11'd5,   32'hffffffff, 5'd0,  16'h0001);
        send_packet(srrt_pkg::CMD_DATA, 11'h7ff,  11'd0,   32'h0,        5'd7,  16'hffff);
    endtask

    // lost reports, completion and a total beyond the bitmap size
    task automatic test_fin_scan();
        send_packet(srrt_pkg::CMD_FIN,  11'd0, 11'd0,   32'h0,        5'd0,  16'h0);
        send_packet(srrt_pkg::CMD_DATA, 11'd2, 11'd3,   32'h00000001, 5'd1,  16'h0002);
        send_packet(srrt_pkg::CMD_FIN,  11'd9, 11'd9,   32'hffffffff, 5'd31, 16'hffff);
        send_packet(srrt_pkg::CMD_DATA, 11'd5, 11'h7ff, 32'hffffffff, 5'd31, 16'hffff);
        send_packet(srrt_pkg::CMD_FIN,  11'd0, 11'd0,   32'h0,        5'd0,  16'h0);
    endtask

    // clear gives no word and empties the message
    task automatic test_clear();
        send_packet(srrt_pkg::CMD_CLEAR, 11'h7ff, 11'h7ff, 32'hffffffff, 5'd31, 16'hffff);
        send_packet(srrt_pkg::CMD_FIN,   11'd0,   11'd0,   32'h0,        5'd0,  16'h0);
        send_packet(srrt_pkg::CMD_DATA,  11'd1,   11'd0,   32'hcafef00d, 5'd4,  16'h00ff);
        send_packet(srrt_pkg::CMD_FIN,   11'd0,   11'd0,   32'h0,        5'd0,  16'h0);
    endtask

    // random messages: clear, data words of one message, noise, then fin
    task automatic test_random_messages();
        int   start_count;
        int   total_pick;
        int   seq_top;
        int   body_len;
        int   roll;
        int   s;
        start_count = words_sent;
        while (words_sent - start_count < RANDOM_WORDS) begin
            steady_run = (words_sent - start_count >= 120) && (words_sent - start_count < 200);
            send_packet(srrt_pkg::CMD_CLEAR, srrt_pkg::SEQ_W'($urandom),
                        srrt_pkg::SEQ_W'($urandom), $urandom,
                        srrt_pkg::SLOT_W'($urandom), srrt_pkg::WIN_W'($urandom));
            if ($urandom_range(0, 2) == 0) begin
                // complete message in order, sometimes with a repeat
                total_pick = $urandom_range(1, 24);
                for (s = 1; s <= total_pick; s++) begin
                    send_packet(srrt_pkg::CMD_DATA, srrt_pkg::SEQ_W'(s),
                                srrt_pkg::SEQ_W'(total_pick), $urandom,
                                srrt_pkg::SLOT_W'($urandom_range(0, 31)),
                                srrt_pkg::WIN_W'($urandom));
                    if ($urandom_range(0, 9) == 0) begin
                        send_packet(srrt_pkg::CMD_DATA, srrt_pkg::SEQ_W'(s),
                                    srrt_pkg::SEQ_W'(total_pick), $urandom,
                                    srrt_pkg::SLOT_W'($urandom_range(0, 31)),
                                    srrt_pkg::WIN_W'($urandom));
                    end
                end
            end else begin
                // mostly small messages, a few reaching past the bitmap
                total_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 2047)
                                                         : $urandom_range(1, 40);
                seq_top  = (total_pick > PACKET_CAP) ? PACKET_CAP : total_pick;
                body_len = $urandom_range(1, 40);
                for (s = 0; s < body_len; s++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 78) begin
                        send_packet(srrt_pkg::CMD_DATA,
                                    srrt_pkg::SEQ_W'($urandom_range(1, seq_top)),
                                    srrt_pkg::SEQ_W'(total_pick), $urandom,
                                    srrt_pkg::SLOT_W'($urandom_range(0, 31)),
                                    srrt_pkg::WIN_W'($urandom));
                    end else if (roll < 84) begin
                        send_packet(srrt_pkg::CMD_FIN, srrt_pkg::SEQ_W'($urandom),
                                    srrt_pkg::SEQ_W'($urandom), $urandom,
                                    srrt_pkg::SLOT_W'($urandom), srrt_pkg::WIN_W'($urandom));
                    end else if (roll < 89) begin
                        send_packet(srrt_pkg::CMD_OTHER, srrt_pkg::SEQ_W'($urandom),
                                    srrt_pkg::SEQ_W'($urandom), $urandom,
                                    srrt_pkg::SLOT_W'($urandom), srrt_pkg::WIN_W'($urandom));
                    end else if (roll < 94) begin
                        send_packet(srrt_pkg::CMD_DATA,
                                    ($urandom_range(0, 1) == 0) ? srrt_pkg::SEQ_W'(0)
                                        : srrt_pkg::SEQ_W'($urandom_range(PACKET_CAP + 1, 2047)),
                                    srrt_pkg::SEQ_W'($urandom), $urandom,
                                    srrt_pkg::SLOT_W'($urandom), srrt_pkg::WIN_W'($urandom));
                    end else begin
                        send_packet(srrt_pkg::cmd_t'($urandom_range(0, 3)),
                                    srrt_pkg::SEQ_W'($urandom),
                                    srrt_pkg::SEQ_W'($urandom), $urandom,
                                    srrt_pkg::SLOT_W'($urandom), srrt_pkg::WIN_W'($urandom));
                    end
                end
            end
            send_packet(srrt_pkg::CMD_FIN, srrt_pkg::SEQ_W'($urandom),
                        srrt_pkg::SEQ_W'($urandom), $urandom,
                        srrt_pkg::SLOT_W'($urandom), srrt_pkg::WIN_W'($urandom));
        end
        steady_run = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_message();
        test_data_acks();
        test_bad_sequence();
        test_fin_scan();
        test_clear();
        test_random_messages();

        // drain, then watch a while for stray words
        s_tvalid <= 1'b0;
        while (ack_words_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d packet words, checked %0d result words", words_sent, words_checked);
        $display("acks %0d, lost reports %0d, all received %0d, ignored %0d, bad sequence %0d",
                 kind_tally[srrt_pkg::KIND_ACK], kind_tally[srrt_pkg::KIND_LOST],
                 kind_tally[srrt_pkg::KIND_ALL_RECEIVED], kind_tally[srrt_pkg::KIND_IGNORED],
                 kind_tally[srrt_pkg::KIND_BAD_SEQ]);
        if (fail_count == 0 && ack_words_due.size() == 0) begin
            $display("selective_repeat_receive_tracker_tb OK");
        end else begin
            $display("selective_repeat_receive_tracker_tb NOT OK");
        end
        $finish;
    end

endmodule
